// ===== rtl/descriptor_free_list_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// descriptor free list allocator assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DFLA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfla assertion failed");

// next-cycle implication
`define DFLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfla assertion failed");

`endif

// ===== rtl/dfla_pkg.sv =====
// ----------------------------------------------------------------------------
// dfla_pkg
// types and codes for the descriptor free list allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfla_pkg;

    localparam int INDEX_W     = 8;
    localparam int INDEX_COUNT = 256;
    localparam int ADDR_W      = 64;
    localparam int SIZE_W      = 9;

    typedef logic [1:0]          action_t;
    typedef logic [1:0]          status_t;
    typedef logic [SIZE_W-1:0]   size_t;

    localparam action_t ACT_ALLOC = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_READ  = 2'd2;
    localparam action_t ACT_NONE  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam size_t SIZE_RESET = 9'd256;

endpackage

// ===== rtl/descriptor_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// descriptor_free_list_allocator_unit
// Virtqueue descriptor table manager: free list of indices threaded through
// per-descriptor links, with physical and virtual buffer addresses per entry.
// Command channel: a word is taken on a rising edge with start high and busy
// low; busy never rises, so one word may be issued on every cycle.
// Actions: allocate pops the list head and stores both addresses, free
// pushes an index back and clears its virtual address, read returns both
// stored addresses. Exhausted list or an index at or above queue_size (capped
// at QUEUE_DEPTH) is reported in status and leaves the state untouched.
// Result channel: done is high for one cycle with the result word; the
// receiver cannot stall it. A word passes the first-stage registers and
// then the result registers; throughput one word per cycle.
// The link table is a synchronous-read memory addressed by the next head,
// so the current head's link is always ready for a back-to-back allocate.
// Configuration: cfg_data writes queue_size whenever cfg_valid is high
// (cfg_ready stays high); write it only while no word is in flight.
// Reset: queue_size returns to 256, the list to 0, 1, 2 ... in order,
// with no clearing pass; stored addresses are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descriptor_free_list_allocator_unit_macros.svh"

module descriptor_free_list_allocator_unit #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dfla_pkg::action_t               action,
    input  logic [dfla_pkg::INDEX_W-1:0]    index,
    input  logic [dfla_pkg::ADDR_W-1:0]     phys_addr,
    input  logic [dfla_pkg::ADDR_W-1:0]     vaddr,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  dfla_pkg::size_t                 cfg_data,
    output logic                            done,
    output logic [dfla_pkg::INDEX_W-1:0]    desc_index,
    output logic [dfla_pkg::ADDR_W-1:0]     stored_phys,
    output logic [dfla_pkg::ADDR_W-1:0]     stored_virt,
    output dfla_pkg::status_t               status
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = (LW > dfla_pkg::SIZE_W) ? LW : dfla_pkg::SIZE_W;
    localparam int LIMIT = (QUEUE_DEPTH < dfla_pkg::INDEX_COUNT) ? QUEUE_DEPTH
                                                                : dfla_pkg::INDEX_COUNT;
    localparam int VW    = $clog2(LIMIT);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // control state
    dfla_pkg::size_t                queue_size_reg;
    logic [LW-1:0]                  head_reg;
    logic [LW-1:0]                  head_next;
    logic [LIMIT-1:0]               link_valid_reg;
    logic                           s1_valid_reg;
    logic                           done_reg;

    // link table and address stores
    logic [LW-1:0]                  link_mem [QUEUE_DEPTH];
    logic [dfla_pkg::ADDR_W-1:0]    phys_mem [QUEUE_DEPTH];
    logic [dfla_pkg::ADDR_W-1:0]    virt_mem [QUEUE_DEPTH];
    logic [LW-1:0]                  link_rd_reg;
    logic [dfla_pkg::ADDR_W-1:0]    phys_rd_reg;
    logic [dfla_pkg::ADDR_W-1:0]    virt_rd_reg;

    // first stage payload
    dfla_pkg::action_t              s1_action_reg;
    dfla_pkg::status_t              s1_status_reg;
    logic [dfla_pkg::INDEX_W-1:0]   s1_index_reg;
    logic [dfla_pkg::ADDR_W-1:0]    s1_phys_reg;
    logic [dfla_pkg::ADDR_W-1:0]    s1_virt_reg;

    // result word
    logic [dfla_pkg::INDEX_W-1:0]   desc_index_reg;
    logic [dfla_pkg::ADDR_W-1:0]    stored_phys_reg;
    logic [dfla_pkg::ADDR_W-1:0]    stored_virt_reg;
    dfla_pkg::status_t              status_reg;

    logic                           accept;
    logic [CW-1:0]                  size_eff;
    logic [CW-1:0]                  qs_ext;
    logic [CW-1:0]                  head_ext;
    logic [CW-1:0]                  idx_ext;
    logic                           head_avail;
    logic                           idx_ok;
    logic                           alloc_ok;
    logic                           free_ok;
    logic [LW-1:0]                  head_link;
    logic [AW-1:0]                  head_addr;
    logic [AW-1:0]                  idx_addr;
    logic [AW-1:0]                  link_raddr;
    dfla_pkg::status_t              status_next;
    logic [dfla_pkg::INDEX_W-1:0]   index_next;
    logic [dfla_pkg::ADDR_W-1:0]    phys_out;
    logic [dfla_pkg::ADDR_W-1:0]    virt_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign qs_ext     = CW'(queue_size_reg);
    assign size_eff   = (qs_ext > DEPTH_C) ? DEPTH_C : qs_ext;
    assign head_ext   = CW'(head_reg);
    assign idx_ext    = CW'(index);
    assign head_avail = head_ext < size_eff;
    assign idx_ok     = idx_ext < size_eff;
    assign alloc_ok   = accept && (action == dfla_pkg::ACT_ALLOC) && head_avail;
    assign free_ok    = accept && (action == dfla_pkg::ACT_FREE) && idx_ok;
    assign head_addr  = head_reg[AW-1:0];
    assign idx_addr   = idx_ext[AW-1:0];

    // never-written links point at the following index
    assign head_link = link_valid_reg[head_ext[VW-1:0]] ? link_rd_reg : head_reg + 1'b1;

    always_comb
    begin
        if (alloc_ok)
        begin
            head_next = head_link;
        end
        else if (free_ok)
        begin
            head_next = idx_ext[LW-1:0];
        end
        else
        begin
            head_next = head_reg;
        end
    end

    assign link_raddr = head_next[AW-1:0];

    always_comb
    begin
        index_next = index;
        case (action)
            dfla_pkg::ACT_ALLOC:
            begin
                status_next = head_avail ? dfla_pkg::ST_OK : dfla_pkg::ST_EMPTY;
                index_next  = head_avail ? head_ext[dfla_pkg::INDEX_W-1:0] : '0;
            end
            dfla_pkg::ACT_FREE, dfla_pkg::ACT_READ:
            begin
                status_next = idx_ok ? dfla_pkg::ST_OK : dfla_pkg::ST_RANGE;
            end
            default:
            begin
                status_next = dfla_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_size_reg <= dfla_pkg::SIZE_RESET;
            head_reg       <= '0;
            link_valid_reg <= '0;
            s1_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                queue_size_reg <= cfg_data;
            end
            head_reg <= head_next;
            if (free_ok)
            begin
                link_valid_reg[idx_ext[VW-1:0]] <= 1'b1;
            end
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // link table, read at the next head with write-through
    always_ff @(posedge clk)
    begin
        if (free_ok)
        begin
            link_mem[idx_addr] <= head_reg;
        end
        if (free_ok && (idx_addr == link_raddr))
        begin
            link_rd_reg <= head_reg;
        end
        else
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_ok)
        begin
            phys_mem[head_addr] <= phys_addr;
        end
        if (accept)
        begin
            phys_rd_reg <= phys_mem[idx_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_ok)
        begin
            virt_mem[head_addr] <= vaddr;
        end
        else if (free_ok)
        begin
            virt_mem[idx_addr] <= '0;
        end
        if (accept)
        begin
            virt_rd_reg <= virt_mem[idx_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_status_reg <= status_next;
            s1_index_reg  <= index_next;
            s1_phys_reg   <= phys_addr;
            s1_virt_reg   <= vaddr;
        end
    end

    always_comb
    begin
        phys_out = '0;
        virt_out = '0;
        if (s1_status_reg == dfla_pkg::ST_OK)
        begin
            case (s1_action_reg)
                dfla_pkg::ACT_ALLOC:
                begin
                    phys_out = s1_phys_reg;
                    virt_out = s1_virt_reg;
                end
                dfla_pkg::ACT_FREE:
                begin
                    phys_out = phys_rd_reg;
                end
                dfla_pkg::ACT_READ:
                begin
                    phys_out = phys_rd_reg;
                    virt_out = virt_rd_reg;
                end
                default:
                begin
                    phys_out = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            desc_index_reg  <= s1_index_reg;
            stored_phys_reg <= phys_out;
            stored_virt_reg <= virt_out;
            status_reg      <= s1_status_reg;
        end
    end

    assign done        = done_reg;
    assign desc_index  = desc_index_reg;
    assign stored_phys = stored_phys_reg;
    assign stored_virt = stored_virt_reg;
    assign status      = status_reg;

    `DFLA_ASSERT_NEXT(a_accept_to_stage, accept, s1_valid_reg)
    `DFLA_ASSERT_NEXT(a_stage_to_done, s1_valid_reg, done_reg)
    `DFLA_ASSERT_NEXT(a_no_spurious_done, !s1_valid_reg, !done_reg)
    `DFLA_ASSERT_NOW(a_head_bounded, 1'b1, head_ext <= DEPTH_C)
    `DFLA_ASSERT_NOW(a_empty_word_zero, done_reg && (status_reg == dfla_pkg::ST_EMPTY), (desc_index_reg == '0) && (stored_phys_reg == '0) && (stored_virt_reg == '0))

endmodule
